// File: rtl/lkd_pkg.sv
// Shared types, codes and a helper function for the LED/key display refresh controller.
package lkd_pkg;

   localparam int StoreDepth  = 16;
   localparam int StoreAw     = 4;
   localparam int NumKeyBytes = 5;
   localparam int KeyBytesW   = 8 * NumKeyBytes;

   // request codes
   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_READ   = 2'd2,
      REQ_BRIGHT = 2'd3
   } req_kind_type;

   // result codes
   localparam logic [1:0] RES_BYTE = 2'd0;
   localparam logic [1:0] RES_KEY  = 2'd1;
   localparam logic [1:0] RES_READ = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_DISPLAY_MODE = 3'd0;
   localparam logic [2:0] CSR_DIGIT_COUNT  = 3'd1;
   localparam logic [2:0] CSR_KEY_COUNT    = 3'd2;
   localparam logic [2:0] CSR_POS_MAP      = 3'd3;
   localparam logic [2:0] CSR_TEST_PAT     = 3'd4;

   // chip command bytes
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
   localparam logic [7:0] CMD_KEY_READ    = 8'h42;
   localparam logic [7:0] CMD_DATA_WRITE  = 8'h40;
   localparam logic [7:0] CMD_ADDR_ZERO   = 8'hC0;
   localparam logic [7:0] TEST_BYTE       = 8'hFF;
   localparam logic [4:0] BRIGHT_ON_BITS  = 5'b10001;  // upper bits of 0x88

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BRIGHT_SET,
      ST_TICK_EVAL,
      ST_MODE,
      ST_BRIGHT,
      ST_KEY_EVAL,
      ST_KEY_CMD,
      ST_KEY_REPORT,
      ST_WRITE_CMD,
      ST_ADDR_CMD,
      ST_DATA_READ,
      ST_DATA_OUT,
      ST_SEG_READ,
      ST_SEG_COMPARE,
      ST_RB_READ,
      ST_RB_OUT
   } state_type;

   typedef enum logic [2:0] {
      SEL_MODE,
      SEL_BRIGHT,
      SEL_KEY_CMD,
      SEL_KEY_REPORT,
      SEL_WRITE_CMD,
      SEL_ADDR_CMD,
      SEL_DATA,
      SEL_READ
   } emit_sel_type;

   typedef struct packed {
      logic         req_take;
      logic         bright_set;
      logic         tick_eval;
      logic         key_eval;
      logic         dirty_clr;
      logic         rd_issue;
      logic         rd_frame;
      logic         seg_commit;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic         req_valid;
      req_kind_type req_kind;
      logic         count_zero;
      logic         key_en;
      logic         key_phase;
      logic         dirty_any;
      logic         dc_zero;
      logic         cnt_last;
      logic         out_free;
   } status_type;

   // first pressed key over the enabled scan bytes; 4 * count when none
   function automatic logic [4:0] decode_keys(input logic [KeyBytesW-1:0] keys,
                                              input logic [2:0]           count);
      logic [4:0] id;
      logic [7:0] b;
      id = {count, 2'b00};
      b  = '0;
      for (int i = NumKeyBytes - 1; i >= 0; i--) begin
         b = keys[i*8 +: 8];
         if (3'(i) < count) begin
            if (b[4]) id = 5'(i * 4 + 3);
            if (b[3]) id = 5'(i * 4 + 2);
            if (b[1]) id = 5'(i * 4 + 1);
            if (b[0]) id = 5'(i * 4);
         end
      end
      return id;
   endfunction

endpackage

// File: rtl/lkd_req_if.sv
// Request channel: valid/ready with one request transaction as payload.
interface lkd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  position;
   logic [7:0]  seg_value;
   logic [3:0]  brightness;
   logic [39:0] key_bytes;

   modport source (output valid, req_type, position, seg_value, brightness, key_bytes,
                   input ready);
   modport sink   (input valid, req_type, position, seg_value, brightness, key_bytes,
                   output ready);
endinterface

// File: rtl/lkd_rsp_if.sv
// Result channel: valid/ready with one result transaction as payload.
interface lkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] out_byte;
   logic       frame_start;
   logic [4:0] key_id;
   logic       last;

   modport source (output valid, result_kind, out_byte, frame_start, key_id, last,
                   input ready);
   modport sink   (input valid, result_kind, out_byte, frame_start, key_id, last,
                   output ready);
endinterface

// File: rtl/lkd_csr_if.sv
// Register write channel: valid/ready with register index and write data.
interface lkd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/lkd_ctrl.sv
// Sequencing state machine: walks each request through its steps and issues datapath commands.
module lkd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  lkd_pkg::status_type status,
   output lkd_pkg::cmd_type    cmd
);
   import lkd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               unique case (status.req_kind)
                  REQ_TICK:   state_in = ST_TICK_EVAL;
                  REQ_WRITE:  state_in = ST_SEG_READ;
                  REQ_READ:   state_in = ST_RB_READ;
                  REQ_BRIGHT: state_in = ST_BRIGHT_SET;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_BRIGHT_SET: state_in = ST_IDLE;
         ST_TICK_EVAL:  state_in = status.count_zero ? ST_MODE : ST_KEY_EVAL;
         ST_MODE:       if (status.out_free) state_in = ST_BRIGHT;
         ST_BRIGHT:     if (status.out_free) state_in = ST_KEY_EVAL;
         ST_KEY_EVAL: begin
            if (status.key_en && status.key_phase) state_in = ST_KEY_CMD;
            else if (status.dirty_any)             state_in = ST_WRITE_CMD;
            else                                   state_in = ST_IDLE;
         end
         ST_KEY_CMD:    if (status.out_free) state_in = ST_KEY_REPORT;
         ST_KEY_REPORT: if (status.out_free) state_in = ST_IDLE;
         ST_WRITE_CMD:  if (status.out_free) state_in = ST_ADDR_CMD;
         ST_ADDR_CMD: begin
            if (status.out_free) state_in = status.dc_zero ? ST_IDLE : ST_DATA_READ;
         end
         ST_DATA_READ:  state_in = ST_DATA_OUT;
         ST_DATA_OUT: begin
            if (status.out_free) state_in = status.cnt_last ? ST_IDLE : ST_DATA_READ;
         end
         ST_SEG_READ:    state_in = ST_SEG_COMPARE;
         ST_SEG_COMPARE: state_in = ST_IDLE;
         ST_RB_READ:     state_in = ST_RB_OUT;
         ST_RB_OUT:      if (status.out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.emit_sel  = SEL_MODE;
      unique case (state_ff)
         ST_IDLE:       cmd.req_take = 1'b1;
         ST_BRIGHT_SET: cmd.bright_set = 1'b1;
         ST_TICK_EVAL:  cmd.tick_eval = 1'b1;
         ST_MODE: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = SEL_MODE;
         end
         ST_BRIGHT: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = SEL_BRIGHT;
         end
         ST_KEY_EVAL:   cmd.key_eval = 1'b1;
         ST_KEY_CMD: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = SEL_KEY_CMD;
         end
         ST_KEY_REPORT: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_KEY_REPORT;
            cmd.emit_last = 1'b1;
         end
         ST_WRITE_CMD: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = SEL_WRITE_CMD;
         end
         ST_ADDR_CMD: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_ADDR_CMD;
            cmd.emit_last = status.dc_zero;
            cmd.dirty_clr = status.out_free;
            cmd.cnt_clr   = status.out_free;
         end
         ST_DATA_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_frame = 1'b1;
         end
         ST_DATA_OUT: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_DATA;
            cmd.emit_last = status.cnt_last;
            cmd.cnt_inc   = status.out_free;
         end
         ST_SEG_READ:    cmd.rd_issue = 1'b1;
         ST_SEG_COMPARE: cmd.seg_commit = 1'b1;
         ST_RB_READ:     cmd.rd_issue = 1'b1;
         ST_RB_OUT: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = SEL_READ;
            cmd.emit_last = 1'b1;
         end
         default: cmd.req_take = 1'b0;
      endcase
   end
endmodule

// File: rtl/lkd_datapath.sv
// Datapath: registers, display store, refresh timer, key decoder and result register.
module lkd_datapath #(
   parameter int MAX_DIGITS    = 16,
   parameter int MAX_KEY_BYTES = 5,
   parameter int REFRESH_TICKS = 100
) (
   input  logic                clock,
   input  logic                reset,
   lkd_req_if.sink             req_ch,
   lkd_rsp_if.source           rsp_ch,
   lkd_csr_if.sink             csr_ch,
   input  lkd_pkg::cmd_type    cmd,
   output lkd_pkg::status_type status
);
   import lkd_pkg::*;

   localparam logic [4:0]  MaxDigitsW = 5'(MAX_DIGITS);
   localparam logic [2:0]  MaxKeysW   = 3'(MAX_KEY_BYTES);
   localparam logic [15:0] ReloadW    = 16'(REFRESH_TICKS);

   // configuration
   logic [7:0]  mode_ff;
   logic [4:0]  digits_ff;
   logic [2:0]  keys_ff;
   logic [63:0] pos_map_ff;
   logic        test_ff;

   // block state
   logic [15:0] countdown_ff;
   logic        key_phase_ff;
   logic [4:0]  cur_key_ff;
   logic [15:0] dirty_ff;
   logic [3:0]  bright_ff;
   logic [StoreDepth-1:0] valid_ff;
   logic        rd_valid_ff;
   logic [4:0]  cnt_ff;

   // latched request
   logic [3:0]  pos_ff;
   logic [7:0]  seg_ff;
   logic [3:0]  bright_req_ff;
   logic [KeyBytesW-1:0] key_bytes_ff;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  byte_ff;
   logic        start_ff;
   logic [4:0]  key_id_ff;
   logic        last_ff;
   logic [1:0]  kind_in;
   logic [7:0]  byte_in;
   logic        start_in;
   logic [4:0]  key_id_in;

   logic [4:0]  dc;
   logic [2:0]  kc;
   logic [StoreAw-1:0] hw_addr;
   logic [StoreAw-1:0] rd_addr;
   logic [7:0]  ram_q;
   logic [7:0]  rd_byte;
   logic        seg_we;
   logic        out_free;
   logic        req_fire;

   assign dc       = (digits_ff > MaxDigitsW) ? MaxDigitsW : digits_ff;
   assign kc       = (keys_ff > MaxKeysW) ? MaxKeysW : keys_ff;
   assign hw_addr  = pos_map_ff[pos_ff*4 +: 4];
   assign rd_addr  = cmd.rd_frame ? cnt_ff[StoreAw-1:0] : hw_addr;
   assign rd_byte  = rd_valid_ff ? ram_q : 8'h00;
   assign seg_we   = cmd.seg_commit && (rd_byte != seg_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && cmd.req_take;

   assign req_ch.ready = cmd.req_take;
   assign csr_ch.ready = 1'b1;

   lkd_ram #(.WIDTH(8), .DEPTH(StoreDepth)) u_store (
      .clock (clock),
      .we    (seg_we),
      .waddr (hw_addr),
      .wdata (seg_ff),
      .re    (cmd.rd_issue),
      .raddr (rd_addr),
      .rdata (ram_q)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         digits_ff  <= '0;
         keys_ff    <= '0;
         pos_map_ff <= '0;
         test_ff    <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DISPLAY_MODE: mode_ff    <= csr_ch.data[7:0];
            CSR_DIGIT_COUNT:  digits_ff  <= csr_ch.data[4:0];
            CSR_KEY_COUNT:    keys_ff    <= csr_ch.data[2:0];
            CSR_POS_MAP:      pos_map_ff <= csr_ch.data;
            CSR_TEST_PAT:     test_ff    <= csr_ch.data[0];
            default:          mode_ff    <= mode_ff;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff        <= req_ch.position;
         seg_ff        <= req_ch.seg_value;
         bright_req_ff <= req_ch.brightness;
         key_bytes_ff  <= req_ch.key_bytes;
      end
   end

   // timer, brightness, key phase and key id, dirty mask, store valid bits, read valid, frame counter
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         key_phase_ff <= 1'b0;
         cur_key_ff   <= '0;
         dirty_ff     <= '0;
         bright_ff    <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.bright_set) begin
            bright_ff    <= bright_req_ff;
            countdown_ff <= '0;
         end
         if (cmd.tick_eval) begin
            if (countdown_ff == 16'd0) begin
               countdown_ff <= ReloadW;
               dirty_ff     <= '1;
            end else begin
               countdown_ff <= countdown_ff - 16'd1;
            end
         end
         if (cmd.key_eval && (kc != 3'd0)) begin
            key_phase_ff <= !key_phase_ff;
            if (key_phase_ff) cur_key_ff <= decode_keys(key_bytes_ff, kc);
         end
         if (cmd.rd_issue) rd_valid_ff <= valid_ff[rd_addr];
         if (seg_we) begin
            valid_ff[hw_addr] <= 1'b1;
            dirty_ff          <= dirty_ff | (16'd1 << hw_addr);
         end
         if (cmd.dirty_clr) dirty_ff <= '0;
         if (cmd.cnt_clr)      cnt_ff <= '0;
         else if (cmd.cnt_inc) cnt_ff <= cnt_ff + 5'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result fields for the selected source
   always_comb begin
      kind_in   = RES_BYTE;
      byte_in   = 8'h00;
      start_in  = 1'b1;
      key_id_in = '0;
      case (cmd.emit_sel)
         SEL_MODE:      byte_in = mode_ff;
         SEL_BRIGHT:    byte_in = bright_ff[3] ? CMD_DISPLAY_OFF
                                               : {BRIGHT_ON_BITS, bright_ff[2:0]};
         SEL_KEY_CMD:   byte_in = CMD_KEY_READ;
         SEL_KEY_REPORT: begin
            kind_in   = RES_KEY;
            start_in  = 1'b0;
            key_id_in = cur_key_ff;
         end
         SEL_WRITE_CMD: byte_in = CMD_DATA_WRITE;
         SEL_ADDR_CMD:  byte_in = CMD_ADDR_ZERO;
         SEL_DATA: begin
            start_in = 1'b0;
            byte_in  = test_ff ? TEST_BYTE : rd_byte;
         end
         SEL_READ: begin
            kind_in  = RES_READ;
            start_in = 1'b0;
            byte_in  = rd_byte;
         end
         default: byte_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         last_ff   <= cmd.emit_last;
         kind_ff   <= kind_in;
         start_ff  <= start_in;
         key_id_ff <= key_id_in;
         byte_ff   <= byte_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.frame_start = start_ff;
   assign rsp_ch.key_id      = key_id_ff;
   assign rsp_ch.last        = last_ff;

   // status to the sequencer
   always_comb begin
      status.req_valid  = req_ch.valid;
      status.req_kind   = req_kind_type'(req_ch.req_type);
      status.count_zero = (countdown_ff == 16'd0);
      status.key_en     = (kc != 3'd0);
      status.key_phase  = key_phase_ff;
      status.dirty_any  = (dirty_ff != 16'd0);
      status.dc_zero    = (dc == 5'd0);
      status.cnt_last   = ((cnt_ff + 5'd1) == dc);
      status.out_free   = out_free;
   end
endmodule

// File: rtl/led_key_display_refresh_controller.sv
// Top level of the LED/key display refresh controller: sequencer plus datapath.
//
// Drives a serial LED/key driver chip. Each request transaction on req_ch is one of
// tick, segment write, segment read or set brightness; the block answers with
// zero or more result transactions on rsp_ch, the final one flagged by last.
// csr_ch writes the mode byte, digit count, key byte count, position map and
// test pattern; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. A request is taken once the
// previous one has loaded its final result into the output register. A read's
// first result follows the store read state; a tick's follows the timer
// evaluation state and, without a refresh, the key evaluation state as well.
// Each display byte takes a registered display store read and then a load of
// the result register.
// Results sit in a single output register; the sequencer loads it again as soon as
// the receiver takes the old one, so a stalled receiver simply holds the
// sequence where it is, with nothing lost.
// Synchronous reset clears the timer (first tick refreshes), dirty mask, key
// phase, brightness, registers and the store valid bits, so the store reads zero.
module led_key_display_refresh_controller #(
   parameter int MAX_DIGITS    = 16,
   parameter int MAX_KEY_BYTES = 5,
   parameter int REFRESH_TICKS = 100
) (
   input  logic      clock,
   input  logic      reset,
   lkd_req_if.sink   req_ch,
   lkd_rsp_if.source rsp_ch,
   lkd_csr_if.sink   csr_ch
);
   import lkd_pkg::*;

   cmd_type    cmd;     // sequencer -> datapath
   status_type status;  // datapath -> sequencer

   lkd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lkd_datapath #(
      .MAX_DIGITS    (MAX_DIGITS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .REFRESH_TICKS (REFRESH_TICKS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );
endmodule

// File: rtl/lkd_checker.sv
// Port-level checker for the refresh controller, bound to the top level.
module lkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] result_kind,
   input logic [7:0] out_byte,
   input logic       frame_start,
   input logic [4:0] key_id,
   input logic       last
);
   import lkd_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last)
                                  && $stable(result_kind) && $stable(key_id))
      else $error("result changed while stalled");

   // no new request while a transaction sequence is still open
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last |-> !(req_valid && req_ready))
      else $error("request taken mid-sequence");

   a_key_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == RES_KEY |-> last && out_byte == 8'h00 && !frame_start)
      else $error("malformed key report");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == RES_READ |-> last && key_id == 5'd0 && !frame_start)
      else $error("malformed read result");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind led_key_display_refresh_controller lkd_checker u_lkd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .result_kind (rsp_ch.result_kind),
   .out_byte    (rsp_ch.out_byte),
   .frame_start (rsp_ch.frame_start),
   .key_id      (rsp_ch.key_id),
   .last        (rsp_ch.last)
);

// File: verif/led_key_display_refresh_controller_tb.sv
// Self-checking testbench for the LED/key display refresh controller.
module led_key_display_refresh_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkd_pkg::*;

   localparam int MAX_DIGITS    = 16;
   localparam int MAX_KEY_BYTES = 5;
   localparam int REFRESH_TICKS = 100;

   // Covers any tail work of a full frame after the owed results have arrived.
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam longint RUN_LIMIT_NS = 10_000_000;

   // One result transaction as seen on rsp_ch.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       start;
      logic [4:0] key;
      logic       last;
   } chip_res_type;

   // One request transaction for req_ch.
   typedef struct packed {
      req_kind_type op;
      logic [3:0]   pos;
      logic [7:0]   seg;
      logic [3:0]   level;
      logic [39:0]  keys;
   } ctl_req_type;

   // Opening row: either a register write or a request; a request row may carry
   // results typed in by hand, used in place of the predictor's.
   typedef struct packed {
      logic                 is_reg;
      logic [2:0]           idx;
      logic [63:0]          wdata;
      ctl_req_type          rq;
      logic                 fixed;
      logic [2:0]           n_fixed;
      chip_res_type [3:0]   fixed_res;
   } stim_row_type;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_LIGHT,
      DRAIN_EVERY_FOURTH,
      DRAIN_COIN
   } drain_mode_type;

   logic clock = 1'b0;
   logic reset;

   lkd_req_if req_ch ();
   lkd_rsp_if rsp_ch ();
   lkd_csr_if csr_ch ();

   led_key_display_refresh_controller #(
      .MAX_DIGITS   (MAX_DIGITS),
      .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .REFRESH_TICKS(REFRESH_TICKS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: registers and the controller's own state
   // ---------------------------------------------------------------------
   logic [7:0]  cfg_mode;
   logic [4:0]  cfg_digits;
   logic [2:0]  cfg_keys;
   logic [63:0] cfg_map;
   logic        cfg_test;

   logic [15:0] countdown;
   logic        key_phase;
   logic [4:0]  cur_key;
   logic [15:0] dirty;
   logic [7:0]  store [16];
   logic [3:0]  level;

   chip_res_type owed [$];     // results the block still owes, oldest first
   int unsigned results_seen = 0;
   int unsigned faults = 0;
   int unsigned burst_left = 0;

   stim_row_type opening_rows [$];

   function automatic chip_res_type mk_res(input logic [1:0] kind, input logic [7:0] data,
                                           input logic start, input logic [4:0] key,
                                           input logic last);
      chip_res_type r;
      r.kind  = kind;
      r.data  = data;
      r.start = start;
      r.key   = key;
      r.last  = last;
      return r;
   endfunction

   // Steps the controller for one accepted request; when keep is set, the
   // resulting chip traffic is queued as owed.
   function automatic void advance_controller(input ctl_req_type rq, input bit keep);
      chip_res_type batch [$];
      chip_res_type r;
      int unsigned kc;
      int unsigned dc;
      int unsigned id;
      bit          hit;
      logic [3:0]  hw;
      kc = (cfg_keys > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cfg_keys;
      dc = (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : cfg_digits;
      hw = cfg_map[{rq.pos, 2'b00} +: 4];
      case (rq.op)
         REQ_TICK: begin
            if (countdown == 0) begin
               countdown = 16'(REFRESH_TICKS);
               batch.push_back(mk_res(RES_BYTE, cfg_mode, 1'b1, 5'd0, 1'b0));
               batch.push_back(mk_res(RES_BYTE,
                                      (level > 7) ? CMD_DISPLAY_OFF
                                                  : {BRIGHT_ON_BITS, level[2:0]},
                                      1'b1, 5'd0, 1'b0));
               dirty = '1;
            end else begin
               countdown = countdown - 16'd1;
            end
            if (kc != 0 && key_phase) begin
               // key tick: priority encode bits 0,1,3,4 of each scan byte in turn
               key_phase = 1'b0;
               batch.push_back(mk_res(RES_BYTE, CMD_KEY_READ, 1'b1, 5'd0, 1'b0));
               id  = 0;
               hit = 0;
               for (int b = 0; b < kc; b++) begin
                  for (int j = 0; j < 4; j++) begin
                     if (!hit) begin
                        if (rq.keys[b * 8 + ((j < 2) ? j : j + 1)]) hit = 1;
                        else id++;
                     end
                  end
               end
               cur_key = 5'(id);
               batch.push_back(mk_res(RES_KEY, 8'd0, 1'b0, cur_key, 1'b0));
            end else begin
               if (kc != 0) key_phase = 1'b1;
               if (dirty != 0) begin
                  batch.push_back(mk_res(RES_BYTE, CMD_DATA_WRITE, 1'b1, 5'd0, 1'b0));
                  batch.push_back(mk_res(RES_BYTE, CMD_ADDR_ZERO, 1'b1, 5'd0, 1'b0));
                  for (int i = 0; i < dc; i++)
                     batch.push_back(mk_res(RES_BYTE, cfg_test ? TEST_BYTE : store[i & 15],
                                            1'b0, 5'd0, 1'b0));
                  dirty = '0;
               end
            end
         end
         REQ_WRITE: begin
            // only a change of stored value marks the digit dirty
            if (store[hw] != rq.seg) begin
               store[hw] = rq.seg;
               dirty[hw] = 1'b1;
            end
         end
         REQ_READ: batch.push_back(mk_res(RES_READ, store[hw], 1'b0, 5'd0, 1'b0));
         default: begin
            level     = rq.level;
            countdown = '0;
         end
      endcase
      if (keep) begin
         foreach (batch[i]) begin
            r      = batch[i];
            r.last = (i == batch.size() - 1);
            owed.push_back(r);
         end
      end
   endfunction

   function automatic stim_row_type req_row(input req_kind_type op, input logic [3:0] pos,
                                            input logic [7:0] seg, input logic [3:0] lvl,
                                            input logic [39:0] keys);
      stim_row_type row;
      row          = '0;
      row.rq.op    = op;
      row.rq.pos   = pos;
      row.rq.seg   = seg;
      row.rq.level = lvl;
      row.rq.keys  = keys;
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic [2:0] idx, input logic [63:0] v);
      stim_row_type row;
      row        = '0;
      row.is_reg = 1'b1;
      row.idx    = idx;
      row.wdata  = v;
      return row;
   endfunction

   function automatic stim_row_type with_result(input stim_row_type row,
                                                input chip_res_type r);
      row.fixed                  = 1'b1;
      row.fixed_res[row.n_fixed] = r;
      row.n_fixed                = row.n_fixed + 3'd1;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: drive at the falling edge, look for acceptance at the rising
   // ---------------------------------------------------------------------
   task automatic offer(input ctl_req_type rq, input bit predicted);
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= rq.op;
      req_ch.position   <= rq.pos;
      req_ch.seg_value  <= rq.seg;
      req_ch.brightness <= rq.level;
      req_ch.key_bytes  <= rq.keys;
      do @(posedge clock); while (!req_ch.ready);
      advance_controller(rq, predicted);
   endtask

   // Bursts of back-to-back transactions separated by random gaps.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock) req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Stop offering, let every owed result arrive, then cover any silent tail work.
   task automatic settle();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_DISPLAY_MODE: cfg_mode   = v[7:0];
         CSR_DIGIT_COUNT:  cfg_digits = v[4:0];
         CSR_KEY_COUNT:    cfg_keys   = v[2:0];
         CSR_POS_MAP:      cfg_map    = v;
         CSR_TEST_PAT:     cfg_test   = v[0];
         default: ;
      endcase
      @(negedge clock) csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type row;
      ctl_req_type  rq;
      bit          regs_open;
      int unsigned n_items;
      int unsigned tick_pct;
      int unsigned pick;
      bit          allow_bright;

      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_TICK;
      req_ch.position   = '0;
      req_ch.seg_value  = '0;
      req_ch.brightness = '0;
      req_ch.key_bytes  = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_DISPLAY_MODE;
      csr_ch.data       = '0;
      reset             = 1'b1;

      // everything clears on reset, so the first tick refreshes
      cfg_mode   = '0;
      cfg_digits = '0;
      cfg_keys   = '0;
      cfg_map    = '0;
      cfg_test   = 1'b0;
      countdown  = '0;
      key_phase  = 1'b0;
      cur_key    = '0;
      dirty      = '0;
      level      = '0;
      foreach (store[i]) store[i] = '0;

      // --- opening rows ---
      // first tick after reset: mode 0, brightness 0, then an empty frame
      row = req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'd0);
      row = with_result(row, mk_res(RES_BYTE, 8'h00, 1'b1, 5'd0, 1'b0));
      row = with_result(row, mk_res(RES_BYTE, {BRIGHT_ON_BITS, 3'd0}, 1'b1, 5'd0, 1'b0));
      row = with_result(row, mk_res(RES_BYTE, CMD_DATA_WRITE, 1'b1, 5'd0, 1'b0));
      row = with_result(row, mk_res(RES_BYTE, CMD_ADDR_ZERO, 1'b1, 5'd0, 1'b1));
      opening_rows.push_back(row);
      // store reads back zero after reset
      row = req_row(REQ_READ, 4'd0, 8'd0, 4'd0, 40'd0);
      row = with_result(row, mk_res(RES_READ, 8'h00, 1'b0, 5'd0, 1'b1));
      opening_rows.push_back(row);
      // nothing dirty and no key scan: idle tick, no transaction at all
      row       = req_row(REQ_TICK, 4'd15, 8'hFF, 4'd15, '1);
      row.fixed = 1'b1;
      opening_rows.push_back(row);
      // widest settings, reversed position map
      opening_rows.push_back(reg_row(CSR_DISPLAY_MODE, 64'hFF));
      opening_rows.push_back(reg_row(CSR_DIGIT_COUNT, 64'd16));
      opening_rows.push_back(reg_row(CSR_KEY_COUNT, 64'd5));
      opening_rows.push_back(reg_row(CSR_POS_MAP, 64'h0123_4567_89AB_CDEF));
      opening_rows.push_back(reg_row(CSR_TEST_PAT, 64'd0));
      opening_rows.push_back(req_row(REQ_WRITE, 4'd0, 8'hFF, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_WRITE, 4'd15, 8'hA5, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_WRITE, 4'd0, 8'hFF, 4'd0, 40'd0)); // unchanged
      opening_rows.push_back(req_row(REQ_READ, 4'd0, 8'd0, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_READ, 4'd15, 8'd0, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_BRIGHT, 4'd0, 8'd0, 4'd15, 40'd0)); // display off
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'd0));  // full 20 bytes
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'd0));  // no key pressed
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, '1));     // clean display
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'h10_0000_0000)); // last key
      opening_rows.push_back(req_row(REQ_WRITE, 4'd3, 8'h3C, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, '1));     // first key wins
      opening_rows.push_back(req_row(REQ_BRIGHT, 4'd0, 8'd0, 4'd7, 40'd0));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'h00_0000_0200));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'h00_0000_0200));
      // oversized counts saturate; test pattern on
      opening_rows.push_back(reg_row(CSR_DISPLAY_MODE, 64'h00));
      opening_rows.push_back(reg_row(CSR_DIGIT_COUNT, 64'd31));
      opening_rows.push_back(reg_row(CSR_KEY_COUNT, 64'd7));
      opening_rows.push_back(reg_row(CSR_POS_MAP, 64'd0));
      opening_rows.push_back(reg_row(CSR_TEST_PAT, 64'd1));
      opening_rows.push_back(req_row(REQ_BRIGHT, 4'd0, 8'd0, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'hE4_E4E4_E4E4));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'hE4_E4E4_E4E4)); // untested bits
      opening_rows.push_back(req_row(REQ_WRITE, 4'd9, 8'h00, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_TICK, 4'd0, 8'd0, 4'd0, 40'd0));
      opening_rows.push_back(req_row(REQ_READ, 4'd12, 8'd0, 4'd0, 40'd0));

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      regs_open = 1'b0;
      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         if (row.is_reg) begin
            if (!regs_open) settle();
            regs_open = 1'b1;
            write_reg(row.idx, row.wdata);
         end else begin
            regs_open = 1'b0;
            offer(row.rq, !row.fixed);
            for (int k = 0; k < row.n_fixed; k++) owed.push_back(row.fixed_res[k]);
            pace();
         end
      end

      // --- random phases, each with its own register settings ---
      // Phase 3 is long, tick-heavy and never sets brightness, so the refresh
      // countdown runs out on its own at least once.
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: begin
               write_reg(CSR_DISPLAY_MODE, 64'hFF);
               write_reg(CSR_DIGIT_COUNT, 64'd16);
               write_reg(CSR_KEY_COUNT, 64'd5);
               write_reg(CSR_POS_MAP, '1);
               write_reg(CSR_TEST_PAT, 64'd0);
            end
            1: begin
               write_reg(CSR_DISPLAY_MODE, 64'h00);
               write_reg(CSR_DIGIT_COUNT, 64'd0);
               write_reg(CSR_KEY_COUNT, 64'd0);
               write_reg(CSR_POS_MAP, 64'd0);
               write_reg(CSR_TEST_PAT, 64'd1);
            end
            default: begin
               write_reg(CSR_DISPLAY_MODE, 64'($urandom_range(0, 255)));
               write_reg(CSR_DIGIT_COUNT, ($urandom_range(0, 3) == 0)
                                          ? 64'($urandom_range(17, 31))
                                          : 64'($urandom_range(0, 16)));
               write_reg(CSR_KEY_COUNT, 64'($urandom_range(0, 7)));
               write_reg(CSR_POS_MAP, {$urandom, $urandom});
               write_reg(CSR_TEST_PAT, 64'($urandom_range(0, 1)));
            end
         endcase

         n_items      = (ph == 3) ? 130 : 33;
         tick_pct     = (ph == 3) ? 92 : 50;
         allow_bright = (ph != 3);
         repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)                          rq.op = REQ_TICK;
            else if (pick < tick_pct + (100 - tick_pct) / 2) rq.op = REQ_WRITE;
            else if (pick % 2 == 0 || !allow_bright)      rq.op = REQ_READ;
            else                                          rq.op = REQ_BRIGHT;
            rq.pos   = 4'($urandom_range(0, 15));
            // a few repeated values so unchanged writes turn up
            rq.seg   = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            rq.level = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
               0:       rq.keys = '0;
               1:       rq.keys = 40'd1 << $urandom_range(0, 39);
               2:       rq.keys = {8'($urandom), 32'($urandom)};
               default: rq.keys = {8'($urandom), 32'($urandom)} & {8'($urandom), 32'($urandom)}
                                  & {8'($urandom), 32'($urandom)};
            endcase
            offer(rq, 1'b1);
            pace();
         end
      end

      settle();
      if (faults == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: stall pattern with one long hold-off
   // ---------------------------------------------------------------------
   initial begin : rsp_drain
      drain_mode_type mode;
      int unsigned span;
      int unsigned cyc;
      bit          held;
      rsp_ch.ready = 1'b0;
      mode = DRAIN_FREE;
      span = 0;
      cyc  = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         // long hold-off well into the random part, started while the sender is
         // offering: the output register fills and the request side backs up
         if (!held && results_seen >= 200 && req_ch.valid) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (span == 0) begin
            mode = drain_mode_type'($urandom_range(0, 3));
            span = $urandom_range(16, 128);
         end
         span--;
         case (mode)
            DRAIN_FREE:         rsp_ch.ready <= 1'b1;
            DRAIN_LIGHT:        rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            DRAIN_EVERY_FOURTH: rsp_ch.ready <= (cyc % 4 == 0);
            default:            rsp_ch.ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // Each result transaction is matched against the oldest owed one.
   always @(posedge clock) begin : rsp_check
      chip_res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (owed.size() == 0) begin
            $error("unexpected result: kind %0d byte %02h", rsp_ch.result_kind,
                   rsp_ch.out_byte);
            faults++;
         end else begin
            want = owed.pop_front();
            if (rsp_ch.result_kind !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_ch.result_kind);
               faults++;
            end
            if (rsp_ch.out_byte !== want.data) begin
               $error("out_byte: expected %02h, got %02h", want.data, rsp_ch.out_byte);
               faults++;
            end
            if (rsp_ch.frame_start !== want.start) begin
               $error("frame_start: expected %0d, got %0d", want.start, rsp_ch.frame_start);
               faults++;
            end
            if (rsp_ch.key_id !== want.key) begin
               $error("key_id: expected %0d, got %0d", want.key, rsp_ch.key_id);
               faults++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               faults++;
            end
         end
      end
   end

   // Hard stop if the run hangs.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
